/* rtl/ptx_pkg.sv */
package ptx_pkg;

  // Request codes
  localparam logic [1:0] REQ_ENQ   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_RX    = 2'd3;

  // Transmit event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_DONE     = 2'd1;
  localparam logic [1:0] EV_TIMEOUT  = 2'd2;
  localparam logic [1:0] EV_STARTERR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BUSY_FORCE = 2'd0;
  localparam logic [1:0] CFG_BUSY_RETRY = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

  localparam logic [31:0] WAIT_IDLE  = 32'hFFFF_FFFF;
  localparam logic [30:0] DL_SAT     = 31'h7FFF_FFFF;

  // One queue slot as stored in the descriptor RAM
  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] release_ms;
    logic [7:0]  tag;
    logic [7:0]  len;
  } slot_t;

  // a strictly after b, modulo 2^32
  function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

/* rtl/ptx_ram.sv */
module ptx_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/priority_tx_scheduler_csma.sv */
// Channel  | Direction | Handshake       | Beat contents
// in_      | input     | in_valid/ready  | request: type, time, descriptor, radio status
// out_     | output    | out_valid/ready | result: accept, start, event, wait, counters
// cfg_     | input     | cfg_we          | register write, index and data
//
// A tick that may start a packet reads the descriptor RAM in two passes, one slot a
// cycle: once to pick the packet to start and once to find the next release. Other
// items skip the first pass; with a transmission armed the second pass is skipped too.
// rst_n is synchronous; it clears the slot valid bits, the timers and the counters.
// The next beat is taken only once the result is in the output register and the
// block is back in idle. A new result waits in its last step while the previous one
// is still held by out_ready.
module priority_tx_scheduler_csma
  import ptx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_pkt_tag,
  input  logic [7:0]  in_pkt_len,
  input  logic [7:0]  in_prio,
  input  logic [30:0] in_delay_ms,
  input  logic        in_channel_busy,
  input  logic        in_send_complete,
  input  logic        in_start_ok,
  input  logic [31:0] in_airtime_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_start_tx,
  output logic [7:0]  out_tx_tag,
  output logic [7:0]  out_tx_len,
  output logic [1:0]  out_tx_event,
  output logic [31:0] out_wait_ms,
  output logic [31:0] out_total_airtime,
  output logic [31:0] out_sent_count,
  output logic [31:0] out_recv_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1) + 1;
  localparam logic [CW-1:0] CNT_END = CW'(QUEUE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SSCAN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_WSCAN  = 7'b0010000,
    S_WEND   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [31:0] force_r;
  logic [30:0] retry_r;
  logic [7:0]  maxlen_r;

  // Captured request
  logic [1:0]  req_r;
  logic [31:0] now_r, air_in_r;
  logic [7:0]  tag_in_r, len_in_r, prio_in_r;
  logic [30:0] delay_r;
  logic        busy_in_r, cmpl_r, sok_r;

  // Scheduler state
  logic [QUEUE_DEPTH-1:0] used_r, used_nxt;
  logic        act_r, act_nxt;
  logic [31:0] begin_r, begin_nxt, dl_r, dl_nxt, nsend_r, nsend_nxt;
  logic [31:0] bsince_r, bsince_nxt, air_r, air_nxt, sent_r, sent_nxt, recv_r, recv_nxt;

  // Result being built
  logic        acc_r, acc_nxt, st_r, st_nxt;
  logic [7:0]  ttag_r, ttag_nxt, tlen_r, tlen_nxt;
  logic [1:0]  ev_r, ev_nxt;

  // Scan engine
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          bv_r, bv_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic [7:0]    bprio_r, bprio_nxt, btag_r, btag_nxt, blen_r, blen_nxt;
  logic          any_r, any_nxt;
  logic [31:0]   early_r, early_nxt;
  logic          tnone_r, tnone_nxt;
  logic [31:0]   tgt_r, tgt_nxt;

  // Output register
  logic        ov_r, ov_nxt;
  logic        o_acc_r, o_st_r;
  logic [7:0]  o_tag_r, o_len_r;
  logic [1:0]  o_ev_r;
  logic [31:0] o_wait_r, o_air_r, o_sent_r, o_recv_r;
  logic        o_load;

  // RAM ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata, ram_rdata;
  logic [IW-1:0] ram_raddr;

  // Combinational helpers
  logic          free_any;
  logic [IW-1:0] free_idx;
  logic          scan_done;
  logic [32:0]  lim_w;
  logic [30:0]  lim;
  logic [31:0]  bs_eff;
  logic [31:0]  wait_v;

  ptx_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(QUEUE_DEPTH),
    .AW   (IW)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign ram_raddr = cnt_r[IW-1:0];
  assign scan_done = (cnt_r == CNT_END) && !pv_r;

  // Find the lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Deadline limit: airtime * 3 / 2, saturated
  always_comb begin
    lim_w = {1'b0, air_in_r} + {2'b00, air_in_r[31:1]};
    lim   = (lim_w > {2'b00, DL_SAT}) ? DL_SAT : lim_w[30:0];
  end

  assign bs_eff = (bsince_r == 32'd0) ? now_r : bsince_r;
  assign wait_v = tnone_r ? WAIT_IDLE :
                  (is_after(tgt_r, now_r) ? (tgt_r - now_r) : 32'd0);
  assign o_load = (state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    act_nxt    = act_r;
    begin_nxt  = begin_r;
    dl_nxt     = dl_r;
    nsend_nxt  = nsend_r;
    bsince_nxt = bsince_r;
    air_nxt    = air_r;
    sent_nxt   = sent_r;
    recv_nxt   = recv_r;
    acc_nxt    = acc_r;
    st_nxt     = st_r;
    ttag_nxt   = ttag_r;
    tlen_nxt   = tlen_r;
    ev_nxt     = ev_r;
    cnt_nxt    = cnt_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    bv_nxt     = bv_r;
    bidx_nxt   = bidx_r;
    bprio_nxt  = bprio_r;
    btag_nxt   = btag_r;
    blen_nxt   = blen_r;
    any_nxt    = any_r;
    early_nxt  = early_r;
    tnone_nxt  = tnone_r;
    tgt_nxt    = tgt_r;
    ov_nxt     = ov_r;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = '{prio: prio_in_r, release_ms: now_r + {1'b0, delay_r},
                   tag: tag_in_r, len: len_in_r};

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      // Apply the request to the registers
      S_EXEC: begin
        acc_nxt   = 1'b0;
        st_nxt    = 1'b0;
        ttag_nxt  = '0;
        tlen_nxt  = '0;
        ev_nxt    = EV_NONE;
        cnt_nxt   = '0;
        pv_nxt    = 1'b0;
        bv_nxt    = 1'b0;
        any_nxt   = 1'b0;
        state_nxt = S_WSCAN;
        case (req_r)
          REQ_ENQ: begin
            if (len_in_r != 8'd0 && len_in_r <= maxlen_r && free_any) begin
              ram_we             = 1'b1;
              used_nxt[free_idx] = 1'b1;
              acc_nxt            = 1'b1;
            end
          end
          REQ_TICK: begin
            if (act_r) begin
              if (cmpl_r) begin
                air_nxt   = air_r + (now_r - begin_r);
                nsend_nxt = now_r;
                act_nxt   = 1'b0;
                sent_nxt  = sent_r + 32'd1;
                ev_nxt    = EV_DONE;
                state_nxt = S_SSCAN;
              end else if (is_after(now_r, dl_r)) begin
                act_nxt   = 1'b0;
                ev_nxt    = EV_TIMEOUT;
                state_nxt = S_SSCAN;
              end
            end else begin
              state_nxt = S_SSCAN;
            end
          end
          REQ_START: begin
            if (sok_r) begin
              act_nxt = 1'b1;
              dl_nxt  = now_r + {1'b0, lim};
            end else begin
              act_nxt = 1'b0;
              ev_nxt  = EV_STARTERR;
            end
          end
          REQ_RX: begin
            recv_nxt = recv_r + 32'd1;
            air_nxt  = air_r + air_in_r;
          end
          default: begin
          end
        endcase
      end

      // Pick the released slot with the lowest priority number
      S_SSCAN: begin
        if (cnt_r != CNT_END) begin
          cnt_nxt  = cnt_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && used_r[pidx_r] && is_after(now_r, ram_rdata.release_ms) &&
            (!bv_r || ram_rdata.prio < bprio_r)) begin
          bv_nxt    = 1'b1;
          bidx_nxt  = pidx_r;
          bprio_nxt = ram_rdata.prio;
          btag_nxt  = ram_rdata.tag;
          blen_nxt  = ram_rdata.len;
        end
        if (scan_done) begin
          state_nxt = S_DECIDE;
        end
      end

      // Apply the backoff rule and start the chosen slot
      S_DECIDE: begin
        cnt_nxt   = '0;
        pv_nxt    = 1'b0;
        state_nxt = S_WSCAN;
        if (bv_r && is_after(now_r, nsend_r)) begin
          if (busy_in_r && !((now_r - bs_eff) > force_r)) begin
            bsince_nxt = bs_eff;
            nsend_nxt  = now_r + {1'b0, retry_r};
          end else begin
            bsince_nxt       = 32'd0;
            used_nxt[bidx_r] = 1'b0;
            begin_nxt        = now_r;
            st_nxt           = 1'b1;
            ttag_nxt         = btag_r;
            tlen_nxt         = blen_r;
          end
        end
      end

      // Find the earliest release among used slots
      S_WSCAN: begin
        if (act_r) begin
          state_nxt = S_WEND;
        end else begin
          if (cnt_r != CNT_END) begin
            cnt_nxt  = cnt_r + CW'(1);
            pv_nxt   = 1'b1;
            pidx_nxt = cnt_r[IW-1:0];
          end else begin
            pv_nxt = 1'b0;
          end
          if (pv_r && used_r[pidx_r] &&
              (!any_r || is_after(early_r, ram_rdata.release_ms))) begin
            any_nxt   = 1'b1;
            early_nxt = ram_rdata.release_ms;
          end
          if (scan_done) begin
            state_nxt = S_WEND;
          end
        end
      end

      // Settle the target time of the next action
      S_WEND: begin
        if (act_r) begin
          tnone_nxt = 1'b0;
          tgt_nxt   = dl_r;
        end else begin
          tnone_nxt = !any_r;
          tgt_nxt   = is_after(nsend_r, early_r) ? nsend_r : early_r;
        end
        state_nxt = S_OUT;
      end

      // Hand the result to the output register
      S_OUT: begin
        if (o_load) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      act_r    <= 1'b0;
      begin_r  <= '0;
      dl_r     <= '0;
      nsend_r  <= '0;
      bsince_r <= '0;
      air_r    <= '0;
      sent_r   <= '0;
      recv_r   <= '0;
      ov_r     <= 1'b0;
      pv_r     <= 1'b0;
      cnt_r    <= '0;
      force_r  <= 32'd2000;
      retry_r  <= 31'd100;
      maxlen_r <= 8'd255;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      act_r    <= act_nxt;
      begin_r  <= begin_nxt;
      dl_r     <= dl_nxt;
      nsend_r  <= nsend_nxt;
      bsince_r <= bsince_nxt;
      air_r    <= air_nxt;
      sent_r   <= sent_nxt;
      recv_r   <= recv_nxt;
      ov_r     <= ov_nxt;
      pv_r     <= pv_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUSY_FORCE: force_r  <= cfg_data;
          CFG_BUSY_RETRY: retry_r  <= cfg_data[30:0];
          CFG_MAX_LEN:    maxlen_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r     <= in_req_type;
      now_r     <= in_now_ms;
      tag_in_r  <= in_pkt_tag;
      len_in_r  <= in_pkt_len;
      prio_in_r <= in_prio;
      delay_r   <= in_delay_ms;
      busy_in_r <= in_channel_busy;
      cmpl_r    <= in_send_complete;
      sok_r     <= in_start_ok;
      air_in_r  <= in_airtime_ms;
    end
    acc_r   <= acc_nxt;
    st_r    <= st_nxt;
    ttag_r  <= ttag_nxt;
    tlen_r  <= tlen_nxt;
    ev_r    <= ev_nxt;
    pidx_r  <= pidx_nxt;
    bv_r    <= bv_nxt;
    bidx_r  <= bidx_nxt;
    bprio_r <= bprio_nxt;
    btag_r  <= btag_nxt;
    blen_r  <= blen_nxt;
    any_r   <= any_nxt;
    early_r <= early_nxt;
    tnone_r <= tnone_nxt;
    tgt_r   <= tgt_nxt;
    if (o_load) begin
      o_acc_r  <= acc_r;
      o_st_r   <= st_r;
      o_tag_r  <= ttag_r;
      o_len_r  <= tlen_r;
      o_ev_r   <= ev_r;
      o_wait_r <= wait_v;
      o_air_r  <= air_r;
      o_sent_r <= sent_r;
      o_recv_r <= recv_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_accepted      = o_acc_r;
  assign out_start_tx      = o_st_r;
  assign out_tx_tag        = o_tag_r;
  assign out_tx_len        = o_len_r;
  assign out_tx_event      = o_ev_r;
  assign out_wait_ms       = o_wait_r;
  assign out_total_airtime = o_air_r;
  assign out_sent_count    = o_sent_r;
  assign out_recv_count    = o_recv_r;

endmodule
